FILE: rtl/page_request_coalescer_macros.svh
// assertion macros shared by the coalescer rtl
`ifndef PAGE_REQUEST_COALESCER_MACROS_SVH
`define PAGE_REQUEST_COALESCER_MACROS_SVH

// same-cycle implication, checked outside reset
`define PCR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("page_request_coalescer check failed");

// next-cycle implication, checked outside reset
`define PCR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("page_request_coalescer check failed");

`endif

FILE: rtl/pcr_pkg.sv
// shared types and constants for the page request coalescer
package pcr_pkg;

    localparam int OFFSET_BITS_DEF     = 48;
    localparam int SCRATCH_BYTES_DEF   = 1 << 20;
    localparam int MAX_CHUNKS_DEF      = 64;
    localparam int MAX_RANGE_PAGES_DEF = 65536;

    localparam int PAGE_BYTES_RST  = 4096;
    localparam int FIELD_PAGES_MAX = 65536;

    localparam int OFFSET_W   = 48;
    localparam int PAGES_W    = 17;
    localparam int SHIFT_W    = 5;
    localparam int LIMIT_W    = 23;
    localparam int SCRATCH_W  = 25;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 17;

    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RST = SHIFT_W'($clog2(PAGE_BYTES_RST));
    localparam logic [SHIFT_W-1:0] SHIFT_MIN      = 5'd9;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX      = 5'd16;

    // register indexes on the config port
    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHUNK_CAP  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_MODE  = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    // settings taken when a range opens
    typedef struct packed {
        logic [SHIFT_W-1:0] shift;
        logic [PAGES_W-1:0] step;   // zero means whole range in one chunk
        logic [LIMIT_W-1:0] limit;
    } cfg_lat_t;

endpackage

FILE: rtl/pcr_cfg.sv
// configuration registers and derived chunking limits
module pcr_cfg import pcr_pkg::*; #(
    parameter int SCRATCH_BYTES   = SCRATCH_BYTES_DEF,
    parameter int MAX_CHUNKS      = MAX_CHUNKS_DEF,
    parameter int MAX_RANGE_PAGES = MAX_RANGE_PAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output cfg_lat_t              cfg_lat
);

    localparam int RANGE_LIM_I = (MAX_RANGE_PAGES > FIELD_PAGES_MAX) ? FIELD_PAGES_MAX :
                                 ((MAX_RANGE_PAGES < 1) ? 1 : MAX_RANGE_PAGES);
    localparam logic [LIMIT_W-1:0]   RANGE_LIM  = LIMIT_W'(RANGE_LIM_I);
    localparam logic [LIMIT_W-1:0]   CHUNKS_MUL = LIMIT_W'(MAX_CHUNKS);
    localparam logic [SCRATCH_W-1:0] SCRATCH    = SCRATCH_W'(SCRATCH_BYTES);
    localparam logic [SCRATCH_W-1:0] PAGES_MAX  = SCRATCH_W'(FIELD_PAGES_MAX);

    logic [SHIFT_W-1:0]   page_shift_reg;
    logic [PAGES_W-1:0]   chunk_cap_reg;
    logic                 read_mode_reg;

    logic [SHIFT_W-1:0]   shift_c;
    logic [PAGES_W-1:0]   cap_c;
    logic [SCRATCH_W-1:0] st_full;
    logic [PAGES_W-1:0]   st;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            page_shift_reg <= PAGE_SHIFT_RST;
            chunk_cap_reg  <= '0;
            read_mode_reg  <= 1'b1;
        end else if (cfg_valid) begin
            case (cfg_addr)
                CFG_PAGE_SHIFT: page_shift_reg <= cfg_wdata[SHIFT_W-1:0];
                CFG_CHUNK_CAP:  chunk_cap_reg  <= cfg_wdata;
                CFG_READ_MODE:  read_mode_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (page_shift_reg < SHIFT_MIN) begin
            shift_c = SHIFT_MIN;
        end else if (page_shift_reg > SHIFT_MAX) begin
            shift_c = SHIFT_MAX;
        end else begin
            shift_c = page_shift_reg;
        end

        cap_c = (chunk_cap_reg > PAGES_W'(FIELD_PAGES_MAX)) ? PAGES_W'(FIELD_PAGES_MAX)
                                                             : chunk_cap_reg;

        // scratch buffer expressed in pages
        st_full = SCRATCH >> shift_c;
        if (st_full == '0) begin
            st = PAGES_W'(1);
        end else if (st_full > PAGES_MAX) begin
            st = PAGES_W'(FIELD_PAGES_MAX);
        end else begin
            st = PAGES_W'(st_full);
        end
        if (cap_c != '0 && st > cap_c) begin
            st = cap_c;
        end

        cfg_lat.shift = shift_c;
        if (read_mode_reg) begin
            cfg_lat.step  = st;
            cfg_lat.limit = LIMIT_W'(st) * CHUNKS_MUL;
        end else if (cap_c != '0) begin
            cfg_lat.step  = cap_c;
            cfg_lat.limit = LIMIT_W'(cap_c) * CHUNKS_MUL;
        end else begin
            cfg_lat.step  = '0;
            cfg_lat.limit = RANGE_LIM;
        end
    end

endmodule

FILE: rtl/pcr_addr_unit.sv
// shared address adder: base plus a page count scaled by the page size
module pcr_addr_unit import pcr_pkg::*; #(
    parameter int OFFSET_BITS = OFFSET_BITS_DEF
) (
    input  logic [OFFSET_BITS-1:0] base,
    input  logic [PAGES_W-1:0]     pages,
    input  logic [SHIFT_W-1:0]     shift,
    output logic [OFFSET_BITS-1:0] sum
);

    logic [OFFSET_BITS-1:0] delta;

    // wraps modulo the address width
    assign delta = OFFSET_BITS'(pages) << shift;
    assign sum   = base + delta;

endmodule

FILE: rtl/page_request_coalescer.sv
// page request coalescer top level: range tracking and chunk sequencer
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-------------------------------------------
//  s_       | s_valid / s_ready          | s_req_type, s_page_offset
//  m_       | m_valid / m_ready          | m_chunk_start, m_chunk_page_count, m_is_last
//  cfg_     | cfg_valid / cfg_ready      | cfg_addr, cfg_wdata
//
// a word that opens, extends or is dropped leaves s_ready high
// a word that closes a range is issued as N chunk words, N = ceil(range pages / step),
// at most MAX_CHUNKS; the shared address adder advances one chunk per cycle while the output register is free
// m_ready low holds the chunk sequencer; s_ready stays low until the last chunk is loaded
// aresetn is synchronous, active low, and leaves no range open
module page_request_coalescer import pcr_pkg::*; #(
    parameter int OFFSET_BITS     = OFFSET_BITS_DEF,
    parameter int SCRATCH_BYTES   = SCRATCH_BYTES_DEF,
    parameter int MAX_CHUNKS      = MAX_CHUNKS_DEF,
    parameter int MAX_RANGE_PAGES = MAX_RANGE_PAGES_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_req_type,
    input  logic [OFFSET_W-1:0]   s_page_offset,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [OFFSET_W-1:0]   m_chunk_start,
    output logic [PAGES_W-1:0]    m_chunk_page_count,
    output logic                  m_is_last,

    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "page_request_coalescer_macros.svh"

    localparam int AW = OFFSET_BITS;

    cfg_lat_t cfg_lat;

    state_t state_reg, state_next;

    // open range
    logic                 range_open_reg, range_open_next;
    logic [AW-1:0]        range_start_reg, range_start_next;
    logic [AW-1:0]        range_end_reg, range_end_next;
    logic [LIMIT_W-1:0]   range_pages_reg, range_pages_next;
    logic [SHIFT_W-1:0]   lat_shift_reg, lat_shift_next;
    logic [PAGES_W-1:0]   lat_step_reg, lat_step_next;
    logic [LIMIT_W-1:0]   lat_limit_reg, lat_limit_next;

    // range being issued
    logic [AW-1:0]        emit_addr_reg, emit_addr_next;
    logic [LIMIT_W-1:0]   emit_rem_reg, emit_rem_next;
    logic [PAGES_W-1:0]   emit_step_reg, emit_step_next;
    logic [SHIFT_W-1:0]   emit_shift_reg, emit_shift_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    logic [OFFSET_W-1:0]  m_start_reg, m_start_next;
    logic [PAGES_W-1:0]   m_count_reg, m_count_next;
    logic                 m_last_reg, m_last_next;

    logic [AW-1:0]        off_w;
    logic                 accept;
    logic                 do_open, do_emit, do_extend;
    logic                 out_free, load;
    logic                 chunk_last;
    logic [PAGES_W-1:0]   want;

    logic [AW-1:0]        add_base, add_sum;
    logic [PAGES_W-1:0]   add_pages;
    logic [SHIFT_W-1:0]   add_shift;

    pcr_cfg #(
        .SCRATCH_BYTES   (SCRATCH_BYTES),
        .MAX_CHUNKS      (MAX_CHUNKS),
        .MAX_RANGE_PAGES (MAX_RANGE_PAGES)
    ) u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg_lat   (cfg_lat)
    );

    pcr_addr_unit #(
        .OFFSET_BITS (AW)
    ) u_addr (
        .base  (add_base),
        .pages (add_pages),
        .shift (add_shift),
        .sum   (add_sum)
    );

    assign cfg_ready          = 1'b1;
    assign m_valid            = m_valid_reg;
    assign m_chunk_start      = m_start_reg;
    assign m_chunk_page_count = m_count_reg;
    assign m_is_last          = m_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            range_open_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            range_open_reg <= range_open_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        range_start_reg <= range_start_next;
        range_end_reg   <= range_end_next;
        range_pages_reg <= range_pages_next;
        lat_shift_reg   <= lat_shift_next;
        lat_step_reg    <= lat_step_next;
        lat_limit_reg   <= lat_limit_next;
        emit_addr_reg   <= emit_addr_next;
        emit_rem_reg    <= emit_rem_next;
        emit_step_reg   <= emit_step_next;
        emit_shift_reg  <= emit_shift_next;
        m_start_reg     <= m_start_next;
        m_count_reg     <= m_count_next;
        m_last_reg      <= m_last_next;
    end

    always_comb begin
        state_next       = state_reg;
        range_open_next  = range_open_reg;
        range_start_next = range_start_reg;
        range_end_next   = range_end_reg;
        range_pages_next = range_pages_reg;
        lat_shift_next   = lat_shift_reg;
        lat_step_next    = lat_step_reg;
        lat_limit_next   = lat_limit_reg;
        emit_addr_next   = emit_addr_reg;
        emit_rem_next    = emit_rem_reg;
        emit_step_next   = emit_step_reg;
        emit_shift_next  = emit_shift_reg;
        m_start_next     = m_start_reg;
        m_count_next     = m_count_reg;
        m_last_next      = m_last_reg;

        off_w     = AW'(s_page_offset);
        s_ready   = (state_reg == ST_IDLE);
        accept    = s_valid && s_ready;
        do_open   = 1'b0;
        do_emit   = 1'b0;
        do_extend = 1'b0;

        if (accept) begin
            if (s_req_type) begin
                do_emit         = range_open_reg;
                range_open_next = 1'b0;
            end else if (!range_open_reg) begin
                do_open = 1'b1;
            end else if (off_w == range_end_reg) begin
                // a full range closes and the same word opens the next one
                if (range_pages_reg >= lat_limit_reg) begin
                    do_emit = 1'b1;
                    do_open = 1'b1;
                end else begin
                    do_extend = 1'b1;
                end
            end else if (off_w > range_end_reg) begin
                do_emit = 1'b1;
                do_open = 1'b1;
            end
        end

        // chunk sizing for the range being issued
        chunk_last = emit_rem_reg <= LIMIT_W'(emit_step_reg);
        want       = chunk_last ? PAGES_W'(emit_rem_reg) : emit_step_reg;
        out_free   = !m_valid_reg || m_ready;
        load       = (state_reg == ST_EMIT) && out_free;

        // adder: next range end while idle, next chunk start while issuing
        if (state_reg == ST_EMIT) begin
            add_base  = emit_addr_reg;
            add_pages = want;
            add_shift = emit_shift_reg;
        end else begin
            // extending: off equals the old end, so off plus one page is the new end
            add_base  = off_w;
            add_pages = PAGES_W'(1);
            add_shift = do_extend ? lat_shift_reg : cfg_lat.shift;
        end

        if (do_emit) begin
            emit_addr_next  = range_start_reg;
            emit_rem_next   = range_pages_reg;
            emit_step_next  = (lat_step_reg != '0) ? lat_step_reg
                                                   : PAGES_W'(range_pages_reg);
            emit_shift_next = lat_shift_reg;
            state_next      = ST_EMIT;
        end

        if (do_extend) begin
            range_end_next   = add_sum;
            range_pages_next = range_pages_reg + LIMIT_W'(1);
        end

        if (do_open) begin
            range_open_next  = 1'b1;
            range_start_next = off_w;
            range_end_next   = add_sum;
            range_pages_next = LIMIT_W'(1);
            lat_shift_next   = cfg_lat.shift;
            lat_step_next    = cfg_lat.step;
            lat_limit_next   = cfg_lat.limit;
        end

        m_valid_next = m_valid_reg && !m_ready;
        if (load) begin
            m_valid_next   = 1'b1;
            m_start_next   = OFFSET_W'(emit_addr_reg);
            m_count_next   = want;
            m_last_next    = chunk_last;
            emit_addr_next = add_sum;
            emit_rem_next  = emit_rem_reg - LIMIT_W'(want);
            if (chunk_last) begin
                state_next = ST_IDLE;
            end
        end
    end

    `PCR_ASSERT_NOW(a_emit_rem_nonzero, aclk, aresetn, state_reg == ST_EMIT, emit_rem_reg != '0)
    `PCR_ASSERT_NOW(a_open_pages_in_limit, aclk, aresetn, range_open_reg, range_pages_reg != '0 && range_pages_reg <= lat_limit_reg)
    `PCR_ASSERT_NOW(a_chunk_fits_step, aclk, aresetn, load, want != '0 && want <= emit_step_reg)
    `PCR_ASSERT_NEXT(a_out_count_nonzero, aclk, aresetn, load, m_valid_reg && m_count_reg != '0)

endmodule

FILE: tb/testbench.sv
// self-checking testbench for page_request_coalescer: chunk predictor class, drivers, stimulus

localparam bit REQ_PAGE  = 1'b0;
localparam bit REQ_FLUSH = 1'b1;

typedef struct packed {
    bit [47:0] start;
    bit [16:0] pages;
    bit        last;
} chunk_t;

class chunk_tracker;
    // register copies
    bit [4:0]  reg_shift;
    bit [16:0] reg_cap;
    bit        reg_read;

    // open range and the settings taken when it opened
    bit [47:0]       open_start;
    bit [47:0]       open_end;
    bit              is_open;
    longint unsigned open_pages;
    int unsigned     cur_shift;
    longint unsigned cur_stride;
    longint unsigned cur_limit;

    chunk_t chunks_due[$];
    int     chunks_seen;
    int     mismatch_count;
    int     dup_count;
    int     limit_hits;

    function new();
        reg_shift  = pcr_pkg::PAGE_SHIFT_RST;
        reg_cap    = '0;
        reg_read   = 1'b1;
        open_start = '0;
        open_end   = '0;
        is_open    = 1'b0;
        open_pages = 0;
        latch_settings();
    endfunction

    function void write_reg(bit [1:0] idx, bit [16:0] val);
        if (idx == pcr_pkg::CFG_PAGE_SHIFT) reg_shift = val[4:0];
        else if (idx == pcr_pkg::CFG_CHUNK_CAP) reg_cap = val;
        else if (idx == pcr_pkg::CFG_READ_MODE) reg_read = val[0];
    endfunction

    function void latch_settings();
        int unsigned     s;
        longint unsigned cap;
        longint unsigned st;
        s = reg_shift;
        if (s < pcr_pkg::SHIFT_MIN) s = pcr_pkg::SHIFT_MIN;
        if (s > pcr_pkg::SHIFT_MAX) s = pcr_pkg::SHIFT_MAX;
        cap = reg_cap;
        if (cap > pcr_pkg::FIELD_PAGES_MAX) cap = pcr_pkg::FIELD_PAGES_MAX;
        cur_shift = s;
        if (reg_read) begin
            st = pcr_pkg::SCRATCH_BYTES_DEF >> s;
            if (st == 0) st = 1;
            if (st > pcr_pkg::FIELD_PAGES_MAX) st = pcr_pkg::FIELD_PAGES_MAX;
            if (cap > 0 && st > cap) st = cap;
            cur_stride = st;
            cur_limit  = st * pcr_pkg::MAX_CHUNKS_DEF;
        end else if (cap > 0) begin
            cur_stride = cap;
            cur_limit  = cap * pcr_pkg::MAX_CHUNKS_DEF;
        end else begin
            // whole range in one chunk, bounded so the count still fits
            cur_stride = 0;
            cur_limit  = pcr_pkg::MAX_RANGE_PAGES_DEF;
            if (cur_limit > pcr_pkg::FIELD_PAGES_MAX) cur_limit = pcr_pkg::FIELD_PAGES_MAX;
            if (cur_limit == 0) cur_limit = 1;
        end
    endfunction

    function void open_at(bit [47:0] off);
        latch_settings();
        open_start = off;
        open_end   = off + (48'd1 << cur_shift);
        open_pages = 1;
        is_open    = 1'b1;
    endfunction

    function void split_range();
        chunk_t          c;
        longint unsigned stride;
        longint unsigned done;
        longint unsigned want;
        int              n;
        stride = (cur_stride != 0) ? cur_stride : open_pages;
        done   = 0;
        n      = 0;
        if (stride == 0) return;
        while (done < open_pages && n < pcr_pkg::MAX_CHUNKS_DEF) begin
            want = open_pages - done;
            if (want > stride) want = stride;
            c.start = open_start + 48'(done << cur_shift);
            c.pages = want[16:0];
            done += want;
            c.last  = (done >= open_pages);
            chunks_due.push_back(c);
            n++;
        end
    endfunction

    function void take_request(bit kind, bit [47:0] off);
        if (kind == REQ_FLUSH) begin
            if (is_open) split_range();
            is_open    = 1'b0;
            open_pages = 0;
            return;
        end
        if (!is_open) begin
            open_at(off);
            return;
        end
        if (off == open_end) begin
            if (open_pages >= cur_limit) begin
                // full range closes, the same offset starts the next one
                limit_hits++;
                split_range();
                open_at(off);
            end else begin
                open_end += 48'd1 << cur_shift;
                open_pages++;
            end
        end else if (off < open_end) begin
            dup_count++;
        end else begin
            split_range();
            open_at(off);
        end
    endfunction

    function void match_chunk(logic [47:0] start, logic [16:0] pages, logic last);
        chunk_t want_c;
        chunks_seen++;
        if (chunks_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("unexpected chunk: start %h pages %0d last %b", start, pages, last);
            return;
        end
        want_c = chunks_due.pop_front();
        if (want_c.start !== start || want_c.pages !== pages || want_c.last !== last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("chunk mismatch: expected %h %0d %b, got %h %0d %b",
                         want_c.start, want_c.pages, want_c.last, start, pages, last);
        end
    endfunction
endclass

module testbench;
    import pcr_pkg::*;

    localparam int CYCLE_LIMIT = 2_000_000;
    localparam int PHASES      = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic                  s_req_type = 1'b0;
    logic [OFFSET_W-1:0]   s_page_offset = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [OFFSET_W-1:0]   m_chunk_start;
    logic [PAGES_W-1:0]    m_chunk_page_count;
    logic                  m_is_last;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    chunk_tracker tracker = new();
    bit  no_idle = 1'b0;
    int  items_sent = 0;
    int  cycle_count = 0;
    int  settings_used = 1;

    int ph_shift [PHASES] = '{9, 16, 12, 0, 31, 13, 10, 12, 0, 0};
    int ph_cap   [PHASES] = '{0, 0, 1, 3, 0, 131071, 5, 65536, 0, 0};
    bit ph_read  [PHASES] = '{1, 1, 1, 0, 0, 1, 0, 0, 0, 0};
    int ph_lead  [PHASES] = '{0, 0, 70, 0, 0, 0, 0, 0, 0, 0};

    page_request_coalescer u_top (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_req_type         (s_req_type),
        .s_page_offset      (s_page_offset),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_chunk_start      (m_chunk_start),
        .m_chunk_page_count (m_chunk_page_count),
        .m_is_last          (m_is_last),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_addr           (cfg_addr),
        .cfg_wdata          (cfg_wdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            tracker.match_chunk(m_chunk_start, m_chunk_page_count, m_is_last);
    end

    // result side: random stall, possibly none, before each chunk word; none while no_idle is set
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            gap = no_idle ? 0 : $urandom_range(0, 9);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
        end
    end

    task automatic send_request(bit kind, bit [47:0] off);
        int gap;
        bit drop;
        gap = no_idle ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_req_type    <= kind;
        s_page_offset <= off;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        drop = (kind == REQ_PAGE) && tracker.is_open && off < tracker.open_end;
        tracker.take_request(kind, off);
        if (!drop) items_sent++;
    endtask

    task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        tracker.write_reg(idx, val);
        @(posedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (tracker.chunks_due.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic run_phase(int budget, int lead);
        int        target;
        int        pick;
        int        len;
        bit [47:0] off;
        target = items_sent + budget;
        repeat (lead) send_request(REQ_PAGE, tracker.open_end);
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_request(REQ_FLUSH, {16'($urandom), 32'($urandom)});
            end else if (pick < 60) begin
                // contiguous pages; now and then long enough to fill a range
                len = ($urandom_range(0, 99) < 15) ? $urandom_range(40, 100)
                                                   : $urandom_range(1, 12);
                if (len > target - items_sent) len = target - items_sent;
                repeat (len) send_request(REQ_PAGE, tracker.open_end);
            end else if (pick < 72) begin
                off = tracker.open_end - 48'($urandom_range(1, 3 << tracker.cur_shift));
                send_request(REQ_PAGE, off);
            end else if (pick < 94) begin
                if ($urandom_range(0, 1))
                    off = tracker.open_end + (48'($urandom_range(1, 8)) << tracker.cur_shift);
                else
                    off = tracker.open_end + 48'($urandom_range(1, 100000));
                send_request(REQ_PAGE, off);
            end else begin
                send_request(REQ_PAGE, {16'($urandom), 32'($urandom)});
            end
        end
    endtask

    initial begin
        int cap;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed words at the reset settings, 4 KiB pages
        send_request(REQ_FLUSH, 48'h0);                  // flush with nothing open
        send_request(REQ_PAGE, 48'h0);
        send_request(REQ_PAGE, 48'h1000);
        send_request(REQ_PAGE, 48'h1000);                // duplicate below the end
        send_request(REQ_PAGE, 48'h2000);
        send_request(REQ_PAGE, 48'd20000);               // unaligned jump closes
        send_request(REQ_PAGE, 48'd20000 + 48'h1000);
        send_request(REQ_FLUSH, 48'hFFFF_FFFF_FFFF);
        send_request(REQ_PAGE, 48'hFFFF_FFFF_F000);      // end wraps to zero
        send_request(REQ_PAGE, 48'h0);
        send_request(REQ_PAGE, 48'hFFFF_FFFF_FFFF);      // end wraps to 0x0FFF
        send_request(REQ_PAGE, 48'h0FFF);
        send_request(REQ_FLUSH, 48'h0);
        send_request(REQ_PAGE, 48'h4000_0000);
        send_request(REQ_PAGE, 48'h4000_1000);           // left open across the next writes
        wait_idle();
        set_reg(CFG_UNUSED, '1);

        for (int p = 0; p < PHASES; p++) begin
            if (p >= 8) begin
                case ($urandom_range(0, 3))
                    0: cap = 0;
                    1: cap = $urandom_range(1, 8);
                    2: cap = $urandom_range(9, 131071);
                    default: cap = FIELD_PAGES_MAX;
                endcase
                ph_shift[p] = $urandom_range(0, 31);
                ph_cap[p]   = cap;
                ph_read[p]  = $urandom_range(0, 1);
            end
            set_reg(CFG_PAGE_SHIFT, CFG_DATA_W'(ph_shift[p]));
            set_reg(CFG_CHUNK_CAP, CFG_DATA_W'(ph_cap[p]));
            set_reg(CFG_READ_MODE, CFG_DATA_W'(ph_read[p]));
            settings_used++;
            no_idle = (p == 1 || p == 5);
            run_phase(42, ph_lead[p]);
            if (p % 2 == 0 || p == PHASES - 1) send_request(REQ_FLUSH, '0);
            wait_idle();
        end

        tracker.mismatch_count += tracker.chunks_due.size();
        $display("%0d words accepted beyond duplicates, %0d duplicates, %0d register settings",
                 items_sent, tracker.dup_count, settings_used);
        $display("%0d chunk words checked, %0d ranges closed at their size limit",
                 tracker.chunks_seen, tracker.limit_hits);
        if (tracker.mismatch_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/pcr_pkg.sv
rtl/pcr_cfg.sv
rtl/pcr_addr_unit.sv
rtl/page_request_coalescer.sv
tb/testbench.sv
